// File: rtl/solenoid_stroke_hold_driver_top_macros.svh
// Assertion macros for the coil driver block.
// Used by the top level only; no other dependencies.
`ifndef SOLENOID_STROKE_HOLD_DRIVER_TOP_MACROS_SVH
`define SOLENOID_STROKE_HOLD_DRIVER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define SSHD_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SSHD_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSHD_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SSHD_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: rtl/sshd_pkg.sv
// Shared types and constants for the coil driver.
// No dependencies.
package sshd_pkg;
   localparam int NUM_CHANNELS_DEF = 14;
   localparam int OUT_W = 14;
   localparam logic [15:0] ENDLESS = 16'hFFFF;
   localparam logic [6:0] TPM_RESET = 7'd10;
   localparam logic [7:0] STROKE_ON_RESET = 8'd2;
   localparam logic [7:0] MIN_OPEN_RESET = 8'd1;
   localparam logic [31:0] CSR_TICKS_PER_MS = 32'd0;

   typedef enum logic [2:0] {
      CMD_TICK = 3'd0, CMD_SWITCH = 3'd1, CMD_RESET_ALL = 3'd2, CMD_DISABLE = 3'd3,
      CMD_CONFIGURE = 3'd4, CMD_FIRE = 3'd5, CMD_RELEASE = 3'd6, CMD_SET_TRIG = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_WALK, ST_MOD, ST_DONE
   } state_type;

   typedef struct packed {
      logic exec;
      logic walk_start;
      logic walk_step;
      logic mod_start;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic need_mod;
      logic mod_done;
      logic last_chan;
   } ctrl_sts_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] channel;
      logic [15:0] stroke_length;
      logic [7:0] stroke_on;
      logic [7:0] stroke_off;
      logic [15:0] hold_length;
      logic [7:0] hold_on;
      logic [7:0] hold_off;
      logic [31:0] trigger_mask;
      logic [7:0] min_open_ms;
      logic [31:0] switch_bits;
      logic power_ok;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] drive_mask;
      logic [OUT_W-1:0] triggered_mask;
      logic [OUT_W-1:0] untriggered_mask;
      logic power_lost;
      logic status;
   } rsp_type;
endpackage

// File: rtl/sshd_req_if.sv
// Valid/ready channel interfaces for items and results.
// Depends on sshd_pkg.
interface sshd_req_if;
   import sshd_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sshd_rsp_if;
   import sshd_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sshd_ctrl.sv
// Controller state machine that sequences one item through the datapath.
// Depends on sshd_pkg.
module sshd_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   output logic out_valid,
   input  logic out_ready,
   input  sshd_pkg::ctrl_sts_type sts,
   output sshd_pkg::ctrl_cmd_type cmd
);
   import sshd_pkg::*;
   state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      in_ready = 1'b0;
      out_valid_in = out_valid_ff && !out_ready;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.is_tick) begin
               cmd.walk_start = 1'b1;
               state_in = ST_WALK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WALK: begin
            if (sts.need_mod) begin
               cmd.mod_start = 1'b1;
               state_in = ST_MOD;
            end else begin
               cmd.walk_step = 1'b1;
               if (sts.last_chan) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               cmd.walk_step = 1'b1;
               state_in = sts.last_chan ? ST_DONE : ST_WALK;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || out_ready) begin
               cmd.finish = 1'b1;
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_valid = out_valid_ff;
endmodule

// File: rtl/sshd_dp.sv
// Datapath: channel state, counters, per-channel evaluation and a serial
// modulo unit. Depends on sshd_pkg.
module sshd_dp #(
   parameter int NUM_CHANNELS = sshd_pkg::NUM_CHANNELS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_fire,
   input  sshd_pkg::req_type req,
   input  logic [6:0] ticks_per_ms,
   input  sshd_pkg::ctrl_cmd_type cmd,
   output sshd_pkg::ctrl_sts_type sts,
   output sshd_pkg::rsp_type rsp
);
   import sshd_pkg::*;
   localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   req_type req_ff;
   logic active_ff [NUM_CHANNELS];
   logic [31:0] start_ff [NUM_CHANNELS];
   logic [15:0] slen_ff [NUM_CHANNELS];
   logic [7:0] son_ff [NUM_CHANNELS];
   logic [7:0] soff_ff [NUM_CHANNELS];
   logic [15:0] hlen_ff [NUM_CHANNELS];
   logic [7:0] hon_ff [NUM_CHANNELS];
   logic [7:0] hoff_ff [NUM_CHANNELS];
   logic [31:0] tmask_ff [NUM_CHANNELS];
   logic [7:0] mopen_ff [NUM_CHANNELS];
   logic [31:0] lopen_ff [NUM_CHANNELS];
   logic [31:0] switches_ff, ms_ff, tick_ff;
   logic [6:0] prescale_ff;
   logic power_ff;
   logic [NUM_CHANNELS-1:0] drive_ff, nd_ff, trig_ff, untrig_ff;
   logic lost_ff, status_ff;
   logic [CW-1:0] ch_ff;
   rsp_type rsp_ff;

   logic [31:0] rem_ff;
   logic [8:0] div_ff;
   logic [5:0] mcnt_ff;
   logic [31:0] quo_ff;
   logic mbusy_ff;

   logic oor;
   logic [CW-1:0] cidx;
   logic [6:0] tpm, ps_inc;

   assign oor = (req_ff.channel >= 8'(NUM_CHANNELS));
   assign cidx = req_ff.channel[CW-1:0];
   assign tpm = (ticks_per_ms == 7'd0) ? 7'd1 : ticks_per_ms;
   assign ps_inc = prescale_ff + 7'd1;

   // Walk evaluation of the current channel.
   logic opened, can_start, act_now, in_stroke, in_hold, pwm_on, pwm_off0;
   logic [31:0] start_now, el;
   logic [16:0] sum_len;
   logic [7:0] on_sel, off_sel;
   assign opened = (tmask_ff[ch_ff] != 32'd0) && ((tmask_ff[ch_ff] & switches_ff) == 32'd0);
   assign can_start = !active_ff[ch_ff] && ((tmask_ff[ch_ff] & switches_ff) != 32'd0)
                      && ((ms_ff - lopen_ff[ch_ff]) >= {24'd0, mopen_ff[ch_ff]});
   assign act_now = active_ff[ch_ff] || can_start;
   assign start_now = can_start ? ms_ff : start_ff[ch_ff];
   assign el = ms_ff - start_now;
   assign sum_len = {1'b0, slen_ff[ch_ff]} + {1'b0, hlen_ff[ch_ff]};
   assign in_stroke = (slen_ff[ch_ff] == ENDLESS) || (el < {16'd0, slen_ff[ch_ff]});
   assign in_hold = !in_stroke && ((hlen_ff[ch_ff] == ENDLESS) || (el < {15'd0, sum_len}));
   assign on_sel = in_stroke ? son_ff[ch_ff] : hon_ff[ch_ff];
   assign off_sel = in_stroke ? soff_ff[ch_ff] : hoff_ff[ch_ff];
   assign pwm_off0 = (off_sel == 8'd0);
   assign pwm_on = rem_ff < {24'd0, on_sel};

   logic phase_drv, chan_drv;
   assign phase_drv = power_ff && (pwm_off0 || pwm_on);
   assign chan_drv = act_now && !(in_hold && opened) && (in_stroke || in_hold) && phase_drv;

   assign sts.is_tick = (req_ff.command == CMD_TICK);
   assign sts.need_mod = act_now && (in_stroke || (in_hold && !opened)) && !pwm_off0;
   assign sts.mod_done = !mbusy_ff;
   assign sts.last_chan = (ch_ff == CW'(NUM_CHANNELS - 1));

   // Restoring divider, one quotient bit per cycle; keeps the remainder.
   logic [32:0] trial;
   assign trial = {rem_ff, quo_ff[31]} - {24'd0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
      end else if (cmd.mod_start) begin
         mbusy_ff <= 1'b1;
      end else if (mbusy_ff && mcnt_ff == 6'd31) begin
         mbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mod_start) begin
         rem_ff <= 32'd0;
         quo_ff <= tick_ff;
         div_ff <= {1'b0, on_sel} + {1'b0, off_sel};
         mcnt_ff <= 6'd0;
      end else if (mbusy_ff) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[31]};
         end
         quo_ff <= {quo_ff[30:0], 1'b0};
         mcnt_ff <= mcnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         req_ff <= req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            active_ff[c] <= 1'b0;
            start_ff[c] <= '0;
            slen_ff[c] <= '0;
            son_ff[c] <= STROKE_ON_RESET;
            soff_ff[c] <= '0;
            hlen_ff[c] <= '0;
            hon_ff[c] <= '0;
            hoff_ff[c] <= '0;
            tmask_ff[c] <= '0;
            mopen_ff[c] <= MIN_OPEN_RESET;
            lopen_ff[c] <= '0;
         end
         switches_ff <= '0;
         ms_ff <= '0;
         tick_ff <= '0;
         prescale_ff <= '0;
         power_ff <= 1'b1;
         drive_ff <= '0;
         nd_ff <= '0;
         trig_ff <= '0;
         untrig_ff <= '0;
         lost_ff <= 1'b0;
         status_ff <= 1'b0;
         ch_ff <= '0;
      end else begin
         if (cmd.exec) begin
            trig_ff <= '0;
            untrig_ff <= '0;
            nd_ff <= '0;
            lost_ff <= 1'b0;
            status_ff <= 1'b0;
            if (cmd.walk_start) begin
               ch_ff <= '0;
            end
            if (req_ff.command >= CMD_DISABLE && oor) begin
               status_ff <= 1'b1;
            end else begin
               case (req_ff.command)
                  CMD_TICK: begin
                     tick_ff <= tick_ff + 32'd1;
                     if (ps_inc >= tpm) begin
                        prescale_ff <= '0;
                        ms_ff <= ms_ff + 32'd1;
                     end else begin
                        prescale_ff <= ps_inc;
                     end
                     lost_ff <= power_ff && !req_ff.power_ok;
                     power_ff <= req_ff.power_ok;
                  end
                  CMD_SWITCH: begin
                     for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if ((tmask_ff[c] & switches_ff & ~req_ff.switch_bits) != 32'd0) begin
                           lopen_ff[c] <= ms_ff;
                        end
                     end
                     switches_ff <= req_ff.switch_bits;
                  end
                  CMD_RESET_ALL: begin
                     for (int c = 0; c < NUM_CHANNELS; c++) begin
                        active_ff[c] <= 1'b0;
                        start_ff[c] <= '0;
                        slen_ff[c] <= '0;
                        son_ff[c] <= STROKE_ON_RESET;
                        soff_ff[c] <= '0;
                        hlen_ff[c] <= '0;
                        hon_ff[c] <= '0;
                        hoff_ff[c] <= '0;
                        tmask_ff[c] <= '0;
                        mopen_ff[c] <= MIN_OPEN_RESET;
                        lopen_ff[c] <= '0;
                     end
                     drive_ff <= '0;
                  end
                  CMD_DISABLE: begin
                     active_ff[cidx] <= 1'b0;
                     drive_ff[cidx] <= 1'b0;
                     hlen_ff[cidx] <= '0;
                     slen_ff[cidx] <= '0;
                     tmask_ff[cidx] <= '0;
                  end
                  CMD_CONFIGURE: begin
                     slen_ff[cidx] <= req_ff.stroke_length;
                     son_ff[cidx] <= req_ff.stroke_on;
                     soff_ff[cidx] <= req_ff.stroke_off;
                     hlen_ff[cidx] <= req_ff.hold_length;
                     hon_ff[cidx] <= req_ff.hold_on;
                     hoff_ff[cidx] <= req_ff.hold_off;
                     tmask_ff[cidx] <= '0;
                     mopen_ff[cidx] <= '0;
                  end
                  CMD_FIRE: begin
                     active_ff[cidx] <= 1'b1;
                     start_ff[cidx] <= ms_ff;
                  end
                  CMD_RELEASE: begin
                     active_ff[cidx] <= 1'b0;
                  end
                  CMD_SET_TRIG: begin
                     tmask_ff[cidx] <= req_ff.trigger_mask;
                     mopen_ff[cidx] <= req_ff.min_open_ms;
                  end
                  default: ;
               endcase
            end
         end
         if (cmd.walk_step) begin
            if (can_start) begin
               active_ff[ch_ff] <= 1'b1;
               start_ff[ch_ff] <= ms_ff;
               trig_ff[ch_ff] <= 1'b1;
            end
            if (act_now) begin
               if (in_stroke) begin
                  nd_ff[ch_ff] <= phase_drv;
               end else if (in_hold) begin
                  if (opened) begin
                     active_ff[ch_ff] <= 1'b0;
                     untrig_ff[ch_ff] <= 1'b1;
                  end else begin
                     nd_ff[ch_ff] <= phase_drv;
                  end
               end else if (opened) begin
                  active_ff[ch_ff] <= 1'b0;
               end
            end
            if (sts.last_chan) begin
               drive_ff <= nd_ff | (NUM_CHANNELS'(chan_drv) << ch_ff);
            end else begin
               ch_ff <= ch_ff + CW'(1);
            end
         end
      end
   end

   function automatic logic [OUT_W-1:0] fit(input logic [NUM_CHANNELS-1:0] v);
      logic [OUT_W+NUM_CHANNELS-1:0] w;
      w = {{OUT_W{1'b0}}, v};
      return w[OUT_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.drive_mask <= fit(drive_ff);
         rsp_ff.triggered_mask <= fit(trig_ff);
         rsp_ff.untriggered_mask <= fit(untrig_ff);
         rsp_ff.power_lost <= lost_ff;
         rsp_ff.status <= status_ff;
      end
   end

   assign rsp = rsp_ff;
endmodule

// File: rtl/solenoid_stroke_hold_driver_top.sv
// Top level of the coil driver: one item at a time. A non-tick item passes through the
// EXEC and DONE states before the controller returns to IDLE, and its result is registered
// on leaving DONE; DONE holds while an earlier result still waits. A tick walks the
// channels one by one and adds a serial modulo for each active channel in a PWM phase with
// a nonzero off time. The result register frees the input while a result waits.
// Synchronous active-high reset restores all channel state and ticks_per_ms = 10.
`include "solenoid_stroke_hold_driver_top_macros.svh"
module solenoid_stroke_hold_driver_top #(
   parameter int NUM_CHANNELS = sshd_pkg::NUM_CHANNELS_DEF
) (
   input  logic clock,
   input  logic reset,
   sshd_req_if.sink req,
   sshd_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import sshd_pkg::*;
   logic [6:0] tpm_ff;
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;
   logic wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff <= TPM_RESET;
      end else if (wr && {29'd0, csr_paddr} == CSR_TICKS_PER_MS) begin
         tpm_ff <= csr_pwdata[6:0];
      end
   end
   assign csr_prdata = ({29'd0, csr_paddr} == CSR_TICKS_PER_MS) ? {25'd0, tpm_ff} : 32'd0;

   sshd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .sts(sts), .cmd(cmd)
   );

   sshd_dp #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
      .clock(clock), .reset(reset), .in_fire(req.valid && req.ready), .req(req.data),
      .ticks_per_ms(tpm_ff), .cmd(cmd), .sts(sts), .rsp(rsp.data)
   );

   `SSHD_ASSERT_IMPL(a_no_accept_busy, clock, reset, (cmd.exec |-> !req.ready), "accept while busy")
   `SSHD_ASSERT_IMPL(a_one_cmd, clock, reset, ($onehot0({cmd.exec, cmd.finish, cmd.mod_start})), "command overlap")
   `SSHD_ASSERT_IMPL(a_rsp_hold, clock, reset, (rsp.valid && !rsp.ready |=> rsp.valid), "result dropped")
endmodule

// File: tb/sv/solenoid_stroke_hold_driver_top_test.sv
// Self-checking testbench for the multi-channel coil driver top level.
// Depends on sshd_pkg, the sshd_req_if/sshd_rsp_if interfaces and the RTL top;
// every result is compared against a planned value or an in-bench model of the coil channels.
`timescale 1ns / 1ps
module solenoid_stroke_hold_driver_top_test;
   import sshd_pkg::*;

   localparam int NCH = NUM_CHANNELS_DEF;
   localparam int SETTLE = 600;
   localparam int LIMIT = 3000000;

   typedef struct {
      req_type r;
      bit known;
      rsp_type want;
   } plan_row;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   sshd_req_if req_ch ();
   sshd_rsp_if rsp_ch ();

   solenoid_stroke_hold_driver_top dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Coil model state.
   logic        coil_active [NCH];
   logic [31:0] coil_start [NCH];
   logic [15:0] coil_stroke_len [NCH];
   logic [7:0]  coil_stroke_on [NCH];
   logic [7:0]  coil_stroke_off [NCH];
   logic [15:0] coil_hold_len [NCH];
   logic [7:0]  coil_hold_on [NCH];
   logic [7:0]  coil_hold_off [NCH];
   logic [31:0] coil_trig [NCH];
   logic [7:0]  coil_min_open [NCH];
   logic [31:0] coil_open_ms [NCH];
   logic [31:0] sw_state, ms_count, tick_count;
   logic [6:0]  prescale, ticks_per_ms;
   logic        power_on;
   logic [13:0] drive_state;

   rsp_type expected_rsp [$];
   int errors, cycles, n_ticks, n_started, n_ended, n_lost;
   bit calm, bursty;
   int stall_left;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
   end

   function automatic void clear_channels();
      for (int c = 0; c < NCH; c++) begin
         coil_active[c] = 0; coil_start[c] = 0; coil_stroke_len[c] = 0;
         coil_stroke_on[c] = 2; coil_stroke_off[c] = 0; coil_hold_len[c] = 0;
         coil_hold_on[c] = 0; coil_hold_off[c] = 0; coil_trig[c] = 0;
         coil_min_open[c] = 1; coil_open_ms[c] = 0;
      end
      drive_state = 0;
   endfunction

   function automatic logic pwm_level(logic [7:0] on, logic [7:0] off);
      logic [31:0] period;
      period = 32'(on) + 32'(off);
      if (off == 0) return power_on;
      return power_on && ((tick_count % period) < 32'(on));
   endfunction

   function automatic logic coil_eval(int c, inout logic [13:0] trig, inout logic [13:0] untrig);
      logic opened;
      logic [31:0] el;
      opened = coil_trig[c] != 0 && (coil_trig[c] & sw_state) == 0;
      if (!coil_active[c] && (coil_trig[c] & sw_state) != 0 &&
          (ms_count - coil_open_ms[c]) >= 32'(coil_min_open[c])) begin
         coil_active[c] = 1;
         coil_start[c] = ms_count;
         trig[c] = 1;
      end
      if (!coil_active[c]) return 0;
      el = ms_count - coil_start[c];
      if (coil_stroke_len[c] == ENDLESS || el < 32'(coil_stroke_len[c]))
         return pwm_level(coil_stroke_on[c], coil_stroke_off[c]);
      if (coil_hold_len[c] == ENDLESS ||
          el < 32'(coil_stroke_len[c]) + 32'(coil_hold_len[c])) begin
         if (opened) begin
            coil_active[c] = 0;
            untrig[c] = 1;
            return 0;
         end
         return pwm_level(coil_hold_on[c], coil_hold_off[c]);
      end
      if (opened) coil_active[c] = 0;
      return 0;
   endfunction

   function automatic rsp_type coil_predict(req_type r);
      rsp_type o;
      logic [13:0] trig, untrig, nd;
      logic [6:0] tpm;
      logic [31:0] gone;
      int ch;
      trig = 0; untrig = 0; nd = 0;
      o.power_lost = 0; o.status = 0;
      ch = r.channel;
      if (r.command >= CMD_DISABLE && ch >= NCH) begin
         o.status = 1;
      end else begin
         case (cmd_type'(r.command))
            CMD_TICK: begin
               tpm = ticks_per_ms == 0 ? 7'd1 : ticks_per_ms;
               tick_count++;
               prescale = prescale + 7'd1;
               if (prescale >= tpm) begin
                  prescale = 0;
                  ms_count++;
               end
               if (power_on && !r.power_ok) o.power_lost = 1;
               power_on = r.power_ok;
               for (int c = 0; c < NCH; c++) nd[c] = coil_eval(c, trig, untrig);
               drive_state = nd;
            end
            CMD_SWITCH: begin
               gone = (sw_state ^ r.switch_bits) & ~r.switch_bits;
               for (int c = 0; c < NCH; c++)
                  if ((coil_trig[c] & gone) != 0) coil_open_ms[c] = ms_count;
               sw_state = r.switch_bits;
            end
            CMD_RESET_ALL: clear_channels();
            CMD_DISABLE: begin
               coil_active[ch] = 0; drive_state[ch] = 0; coil_hold_len[ch] = 0;
               coil_stroke_len[ch] = 0; coil_trig[ch] = 0;
            end
            CMD_CONFIGURE: begin
               coil_stroke_len[ch] = r.stroke_length; coil_stroke_on[ch] = r.stroke_on;
               coil_stroke_off[ch] = r.stroke_off; coil_hold_len[ch] = r.hold_length;
               coil_hold_on[ch] = r.hold_on; coil_hold_off[ch] = r.hold_off;
               coil_trig[ch] = 0; coil_min_open[ch] = 0;
            end
            CMD_FIRE: begin
               coil_active[ch] = 1;
               coil_start[ch] = ms_count;
            end
            CMD_RELEASE: coil_active[ch] = 0;
            default: begin
               coil_trig[ch] = r.trigger_mask;
               coil_min_open[ch] = r.min_open_ms;
            end
         endcase
      end
      o.drive_mask = drive_state;
      o.triggered_mask = trig;
      o.untriggered_mask = untrig;
      return o;
   endfunction

   function automatic req_type blank_item(cmd_type cmd, int ch);
      req_type r;
      r = '0;
      r.command = cmd;
      r.channel = 8'(ch);
      r.power_ok = 1;
      return r;
   endfunction

   function automatic rsp_type plain_rsp(logic [13:0] drv, logic lost, logic st);
      rsp_type o;
      o = '0;
      o.drive_mask = drv;
      o.power_lost = lost;
      o.status = st;
      return o;
   endfunction

   function automatic req_type random_item();
      req_type r;
      int pick, ch;
      pick = $urandom_range(0, 99);
      ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, NCH - 1);
      r.command = CMD_TICK; r.channel = 8'(ch);
      r.stroke_length = 16'($urandom); r.stroke_on = 8'($urandom);
      r.stroke_off = 8'($urandom);
      r.hold_length = 16'($urandom); r.hold_on = 8'($urandom); r.hold_off = 8'($urandom);
      r.trigger_mask = $urandom; r.min_open_ms = 8'($urandom); r.switch_bits = $urandom;
      r.power_ok = $urandom_range(0, 9) != 0;
      if (pick < 50) begin
         r.command = CMD_TICK;
      end else if (pick < 60) begin
         r.command = CMD_SWITCH;
         if ($urandom_range(0, 4) != 0) r.switch_bits = $urandom & 32'h3FFF;
      end else if (pick < 62) begin
         r.command = CMD_RESET_ALL;
      end else if (pick < 66) begin
         r.command = CMD_DISABLE;
      end else if (pick < 76) begin
         r.command = CMD_CONFIGURE;
         if ($urandom_range(0, 5) != 0) begin
            r.stroke_length = 16'($urandom_range(0, 12));
            r.hold_length = ($urandom_range(0, 4) == 0) ? ENDLESS : 16'($urandom_range(0, 20));
            r.stroke_on = 8'($urandom_range(0, 4)); r.stroke_off = 8'($urandom_range(0, 3));
            r.hold_on = 8'($urandom_range(0, 4)); r.hold_off = 8'($urandom_range(0, 3));
         end
      end else if (pick < 84) begin
         r.command = CMD_FIRE;
      end else if (pick < 89) begin
         r.command = CMD_RELEASE;
      end else begin
         r.command = CMD_SET_TRIG;
         if ($urandom_range(0, 4) != 0) begin
            r.trigger_mask = 32'h1 << $urandom_range(0, 13);
            r.min_open_ms = 8'($urandom_range(0, 3));
         end
      end
      return r;
   endfunction

   task automatic send_item(req_type r, bit known, rsp_type want);
      rsp_type guess;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.data <= r;
      do @(posedge clock); while (!req_ch.ready);
      guess = coil_predict(r);
      if (r.command == CMD_TICK) n_ticks++;
      expected_rsp.push_back(known ? want : guess);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_tpm(logic [6:0] value);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= CSR_TICKS_PER_MS[2:0]; csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      ticks_per_ms = value;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (calm) begin
         rsp_ch.ready <= 1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 0;
      end else if (bursty && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= 1;
      end
      if (!reset && $urandom_range(0, 199) == 0) bursty <= ~bursty;
   end

   always @(posedge clock) begin
      rsp_type want, got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
         end else begin
            want = expected_rsp.pop_front();
            if (got.triggered_mask) n_started++;
            if (got.untriggered_mask) n_ended++;
            if (got.power_lost) n_lost++;
            if (got.drive_mask !== want.drive_mask ||
                got.triggered_mask !== want.triggered_mask ||
                got.untriggered_mask !== want.untriggered_mask ||
                got.power_lost !== want.power_lost || got.status !== want.status) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: drive %h/%h trig %h/%h untrig %h/%h lost %b/%b st %b/%b",
                     want.drive_mask, got.drive_mask, want.triggered_mask,
                     got.triggered_mask, want.untriggered_mask, got.untriggered_mask,
                     want.power_lost, got.power_lost, want.status, got.status);
            end
         end
      end
   end

   initial begin
      plan_row plan [$];
      plan_row row;
      logic [6:0] rates [6];
      rsp_type none;
      none = '0;
      rates = '{7'd1, 7'd0, 7'd127, 7'd100, 7'd10, 7'd3};
      errors = 0; calm = 0; bursty = 1; stall_left = 0;
      reset <= 1;
      req_ch.valid <= 0; req_ch.data <= '0;
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0; csr_paddr <= 0; csr_pwdata <= 0;
      clear_channels();
      sw_state = 0; ms_count = 0; tick_count = 0; prescale = 0; power_on = 1;
      ticks_per_ms = TPM_RESET;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      row.known = 1; row.r = blank_item(CMD_TICK, 0); row.want = plain_rsp(0, 0, 0);
      plan.push_back(row);
      row.r = blank_item(CMD_FIRE, 255); row.want = plain_rsp(0, 0, 1); plan.push_back(row);
      row.r = blank_item(CMD_CONFIGURE, NCH); row.want = plain_rsp(0, 0, 1); plan.push_back(row);
      row.r = blank_item(CMD_SET_TRIG, 200); row.r.trigger_mask = '1;
      row.want = plain_rsp(0, 0, 1); plan.push_back(row);
      row.r = blank_item(CMD_DISABLE, NCH); row.want = plain_rsp(0, 0, 1); plan.push_back(row);
      row.r = blank_item(CMD_RELEASE, 128); row.want = plain_rsp(0, 0, 1); plan.push_back(row);
      row.r = blank_item(CMD_TICK, 0); row.r.power_ok = 0;
      row.want = plain_rsp(0, 1, 0); plan.push_back(row);
      row.want = plain_rsp(0, 0, 0); plan.push_back(row);
      row.r.power_ok = 1; plan.push_back(row);
      row.known = 0; row.want = none;
      row.r = blank_item(CMD_CONFIGURE, 0); row.r.stroke_length = 2; row.r.stroke_on = 1;
      row.r.stroke_off = 1; row.r.hold_length = ENDLESS; row.r.hold_on = 3; plan.push_back(row);
      row.r = blank_item(CMD_FIRE, 0); plan.push_back(row);
      row.r = blank_item(CMD_TICK, 0);
      repeat (4) plan.push_back(row);
      row.r = blank_item(CMD_CONFIGURE, NCH - 1); row.r.stroke_length = ENDLESS;
      row.r.stroke_on = 8'hFF; row.r.stroke_off = 8'hFF; plan.push_back(row);
      row.r = blank_item(CMD_SET_TRIG, NCH - 1); row.r.trigger_mask = '1;
      row.r.min_open_ms = 8'hFF; plan.push_back(row);
      row.r = blank_item(CMD_SWITCH, 0); row.r.switch_bits = '1; plan.push_back(row);
      row.r = blank_item(CMD_TICK, 0); plan.push_back(row);
      row.r = blank_item(CMD_SET_TRIG, 0); row.r.trigger_mask = 1; plan.push_back(row);
      row.r = blank_item(CMD_TICK, 0); plan.push_back(row);
      row.r = blank_item(CMD_SWITCH, 0); plan.push_back(row);
      row.r = blank_item(CMD_TICK, 0); plan.push_back(row);
      row.r = blank_item(CMD_RELEASE, 0); plan.push_back(row);
      row.r = blank_item(CMD_DISABLE, NCH - 1); plan.push_back(row);
      row.known = 1; row.r = blank_item(CMD_RESET_ALL, 0); row.want = plain_rsp(0, 0, 0);
      plan.push_back(row);

      foreach (plan[i]) send_item(plan[i].r, plan[i].known, plan[i].want);

      foreach (rates[p]) begin
         drain();
         write_tpm(rates[p]);
         if (p == 5) calm = 1;
         repeat (85) send_item(random_item(), 0, none);
      end

      req_ch.valid <= 0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (expected_rsp.size() != 0) errors++;
      $display("covered %0d ticks, %0d switch starts, %0d switch releases, %0d power drops",
         n_ticks, n_started, n_ended, n_lost);
      $display("six tick-rate settings, %0d mismatches", errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// File: files.f
+incdir+rtl
rtl/sshd_pkg.sv
rtl/sshd_req_if.sv
rtl/sshd_ctrl.sv
rtl/sshd_dp.sv
rtl/solenoid_stroke_hold_driver_top.sv
tb/sv/solenoid_stroke_hold_driver_top_test.sv
